// ===== src/mme_pkg.sv =====
// Shared types and codes for the matrix multiply engine.
// Used by every module of the block but mme_ram; depends on nothing.
package mme_pkg;

	localparam int IDX_W   = 3;
	localparam int DIM_W   = 4;
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 36;

	localparam logic [1:0] OP_WRITE_A = 2'd0;
	localparam logic [1:0] OP_WRITE_B = 2'd1;
	localparam logic [1:0] OP_MULT    = 2'd2;

	localparam logic [1:0] REG_A_ROWS = 2'd0;
	localparam logic [1:0] REG_A_COLS = 2'd1;
	localparam logic [1:0] REG_B_ROWS = 2'd2;
	localparam logic [1:0] REG_B_COLS = 2'd3;

	typedef enum logic [1:0] {
		STAT_DONE,
		STAT_RANGE,
		STAT_MISMATCH,
		STAT_PRODUCT
	} status_t;

	typedef enum logic [1:0] {
		CMD_WRITE_A,
		CMD_WRITE_B,
		CMD_STATUS,
		CMD_MULT
	} cmd_kind_t;

	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_rows;
		logic [DIM_W-1:0] b_cols;
	} cfg_t;

	// Work handed from the front to the back. Dimensions are already clamped.
	typedef struct packed {
		cmd_kind_t          kind;
		status_t            status;
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [VALUE_W-1:0] value;
		logic [DIM_W-1:0]   m;
		logic [DIM_W-1:0]   n;
		logic [DIM_W-1:0]   p;
	} cmd_t;

endpackage

// ===== src/mme_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mme_front.sv =====
// Front end: takes input words, clamps the sizes, checks ranges and size agreement,
// and registers one command per kept word for the queue. Depends on mme_pkg.
module mme_front import mme_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [IDX_W-1:0]   row,
	input  logic [IDX_W-1:0]   col,
	input  logic [VALUE_W-1:0] value,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);

	localparam logic [DIM_W-1:0] MAX_D = DIM_W'(MAX_DIM);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (r > MAX_D) begin
			d = MAX_D;
		end else begin
			d = r;
		end
		return d;
	endfunction

	logic [DIM_W-1:0] ar, ac, br, bc;
	logic             a_in, b_in;
	logic             keep;
	cmd_t             nxt;
	logic             vld_s1;
	cmd_t             cmd_s1;

	assign ar = eff_dim(cfg.a_rows);
	assign ac = eff_dim(cfg.a_cols);
	assign br = eff_dim(cfg.b_rows);
	assign bc = eff_dim(cfg.b_cols);

	assign a_in = ({1'b0, row} < ar) && ({1'b0, col} < ac);
	assign b_in = ({1'b0, row} < br) && ({1'b0, col} < bc);

	always_comb begin
		nxt        = '0;
		nxt.row    = row;
		nxt.col    = col;
		nxt.value  = value;
		nxt.m      = ar;
		nxt.n      = ac;
		nxt.p      = bc;
		nxt.kind   = CMD_STATUS;
		nxt.status = STAT_RANGE;
		keep       = 1'b1;
		case (op)
			OP_WRITE_A: begin
				if (a_in) begin
					nxt.kind = CMD_WRITE_A;
				end
			end
			OP_WRITE_B: begin
				if (b_in) begin
					nxt.kind = CMD_WRITE_B;
				end
			end
			OP_MULT: begin
				if (ac != br) begin
					nxt.status = STAT_MISMATCH;
				end else begin
					nxt.kind = CMD_MULT;
				end
			end
			default: begin
				// The unused selector is taken and dropped.
				keep = 1'b0;
			end
		endcase
	end

	assign in_ready  = !vld_s1 || cmd_ready;
	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= keep;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= nxt;
		end
	end

endmodule

// ===== src/mme_queue.sv =====
// Short command queue between the front end and the execution back end.
// Depends on mme_pkg for the command type.
module mme_queue import mme_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	cmd_t          buf_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push, pop;

	assign push_ready = (count_q != (PW + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = buf_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/mme_back.sv =====
// Back end: element stores, write execution, the multiply-accumulate
// sequencer and the result register. Depends on mme_pkg and mme_ram.
module mme_back import mme_pkg::*; #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  cmd_t             cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output status_t          out_status,
	output logic [IDX_W-1:0] out_row,
	output logic [IDX_W-1:0] out_col,
	output logic [SUM_W-1:0] out_sum,
	output logic             out_last
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        i_q, j_q, k_q;
	logic [DIM_W-1:0]        m_q, n_q, p_q;
	logic [DEPTH-1:0]        a_vld_q, b_vld_q;
	logic                    vld_s1, first_s1, last_s1, aok_s1, bok_s1;
	logic                    vld_s2, first_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [SUM_W-1:0]        acc_q;
	logic                    done_q;
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [IDX_W-1:0]        out_row_q, out_col_q;
	logic [SUM_W-1:0]        out_sum_q;
	logic                    out_last_q;

	logic                    out_free, start, wr_a, wr_b, issue, k_last;
	logic                    out_take_cmd, out_take_prod;
	logic [AW-1:0]           wr_addr, rd_addr_a, rd_addr_b;
	logic [ELEM_WIDTH-1:0]   wr_data, rdata_a, rdata_b, a_elem, b_elem;
	logic signed [EXT_W-1:0] prod_ext;

	assign out_free  = !out_valid_q || out_ready;
	assign start     = (state_q == S_IDLE) && cmd_valid && out_free;
	assign cmd_ready = start;
	assign wr_a      = start && (cmd.kind == CMD_WRITE_A);
	assign wr_b      = start && (cmd.kind == CMD_WRITE_B);
	assign issue     = (state_q == S_ISSUE);
	assign k_last    = ({1'b0, k_q} == n_q - 1'b1);

	// A write or status command loads the result register at once; a product
	// element loads it once its sum has settled and the register is free.
	assign out_take_cmd  = start && (cmd.kind != CMD_MULT);
	assign out_take_prod = (state_q == S_WAIT) && done_q && out_free;

	assign wr_addr   = AW'(32'(cmd.row) * MAX_DIM + 32'(cmd.col));
	assign rd_addr_a = AW'(32'(i_q) * MAX_DIM + 32'(k_q));
	assign rd_addr_b = AW'(32'(k_q) * MAX_DIM + 32'(j_q));
	assign wr_data   = ELEM_WIDTH'(cmd.value);

	mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
		.clk  (clk),
		.we   (wr_a),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr_a),
		.rdata(rdata_a)
	);

	mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
		.clk  (clk),
		.we   (wr_b),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr_b),
		.rdata(rdata_b)
	);

	// An entry never written since reset reads as zero.
	assign a_elem   = aok_s1 ? rdata_a : '0;
	assign b_elem   = bok_s1 ? rdata_b : '0;
	assign prod_ext = EXT_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			m_q          <= '0;
			n_q          <= '0;
			p_q          <= '0;
			a_vld_q      <= '0;
			b_vld_q      <= '0;
			vld_s1       <= 1'b0;
			vld_s2       <= 1'b0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= STAT_DONE;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_sum_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (vld_s2 && last_s2) begin
				done_q <= 1'b1;
			end else if (out_take_prod) begin
				done_q <= 1'b0;
			end
			if (out_take_cmd || out_take_prod) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_a) begin
				a_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_b) begin
				b_vld_q[wr_addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.kind == CMD_MULT) begin
							m_q     <= cmd.m;
							n_q     <= cmd.n;
							p_q     <= cmd.p;
							i_q     <= '0;
							j_q     <= '0;
							k_q     <= '0;
							state_q <= S_ISSUE;
						end else begin
							out_status_q <= (cmd.kind == CMD_STATUS) ? cmd.status : STAT_DONE;
							out_row_q    <= '0;
							out_col_q    <= '0;
							out_sum_q    <= '0;
							out_last_q   <= 1'b1;
						end
					end
				end
				S_ISSUE: begin
					if (k_last) begin
						k_q     <= '0;
						state_q <= S_WAIT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (out_take_prod) begin
						out_status_q <= STAT_PRODUCT;
						out_row_q    <= i_q;
						out_col_q    <= j_q;
						out_sum_q    <= acc_q;
						out_last_q   <= ({1'b0, i_q} == m_q - 1'b1)
							&& ({1'b0, j_q} == p_q - 1'b1);
						if ({1'b0, j_q} == p_q - 1'b1) begin
							j_q <= '0;
							if ({1'b0, i_q} == m_q - 1'b1) begin
								state_q <= S_IDLE;
							end else begin
								i_q     <= i_q + 1'b1;
								state_q <= S_ISSUE;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Multiply-accumulate datapath: read, multiply, accumulate.
	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= k_last;
		aok_s1   <= a_vld_q[rd_addr_a];
		bok_s1   <= b_vld_q[rd_addr_b];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= $signed(a_elem) * $signed(b_elem);
		if (vld_s2) begin
			acc_q <= first_s2 ? prod_ext[SUM_W-1:0] : acc_q + prod_ext[SUM_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_sum    = out_sum_q;
	assign out_last   = out_last_q;

endmodule

// ===== src/matrix_multiply_engine.sv =====
// Matrix multiply engine: element loads into two stores, full-precision product.
// A load or an error word passes through the front register, the command queue and
// the result register; loads sustain one word per cycle while the receiver is ready
// and no multiply runs. Product elements are summed one at a time on the single
// multiply-accumulate unit. Reset is asynchronous, active low: sizes return to 8
// and every element reads as zero until it is written again.
module matrix_multiply_engine import mme_pkg::*; #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [23:0]      s_tdata,  // row[2:0], col[5:3], value[21:6], zero fill
	input  logic [1:0]       s_tuser,  // op[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [47:0]      m_tdata,  // out_row[2:0], out_col[5:3], sum[41:6], zero fill
	output logic [1:0]       m_tuser,  // status[1:0]
	output logic             m_tlast
);

	cfg_t             cfg_q;
	logic             f_valid, f_ready, q_valid, q_ready;
	cmd_t             f_cmd, q_cmd;
	status_t          st;
	logic [IDX_W-1:0] o_row, o_col;
	logic [SUM_W-1:0] o_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_rows <= DIM_W'(8);
			cfg_q.a_cols <= DIM_W'(8);
			cfg_q.b_rows <= DIM_W'(8);
			cfg_q.b_cols <= DIM_W'(8);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_A_ROWS: cfg_q.a_rows <= cfg_data;
				REG_A_COLS: cfg_q.a_cols <= cfg_data;
				REG_B_ROWS: cfg_q.b_rows <= cfg_data;
				REG_B_COLS: cfg_q.b_cols <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mme_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (s_tuser),
		.row      (s_tdata[2:0]),
		.col      (s_tdata[5:3]),
		.value    (s_tdata[21:6]),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd      (f_cmd)
	);

	mme_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data (f_cmd),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_data  (q_cmd)
	);

	mme_back #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(st),
		.out_row   (o_row),
		.out_col   (o_col),
		.out_sum   (o_sum),
		.out_last  (m_tlast)
	);

	assign m_tuser = st;
	assign m_tdata = {6'b0, o_sum, o_col, o_row};

endmodule

// ===== sim/tb_matrix_multiply_engine.sv =====
// Self-checking testbench for matrix_multiply_engine: element loads, range errors,
// size mismatches and full products, checked word by word against a local predictor.
// Depends on mme_pkg and matrix_multiply_engine only.
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;
	import mme_pkg::*;

	localparam int          DIM           = 8;
	localparam int          RANDOM_ITEMS  = 160;
	localparam int          SETTLE_CYCLES = 16;
	localparam int          DRAIN_LIMIT   = 100000;
	localparam logic [1:0]  OP_UNUSED     = 2'd3;

	typedef struct packed {
		status_t     status;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [35:0] total;
		logic        last;
	} mme_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [DIM_W-1:0]  cfg_data;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;
	logic [1:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [47:0]       m_tdata;
	logic [1:0]        m_tuser;
	logic              m_tlast;

	bit calm;

	// A size register of 0 acts as 1, anything above the store size as the store size.
	function automatic int unsigned act_dim(logic [3:0] r);
		if (r == 4'd0) return 1;
		if (r > DIM) return DIM;
		return r;
	endfunction

	class matmul_scoreboard;
		logic [15:0] a_mem [DIM*DIM];
		logic [15:0] b_mem [DIM*DIM];
		logic [3:0]  a_rows, a_cols, b_rows, b_cols;
		mme_word_t   awaited [$];
		int          errors;

		function new();
			foreach (a_mem[i]) begin
				a_mem[i] = '0;
				b_mem[i] = '0;
			end
			a_rows = 4'd8;
			a_cols = 4'd8;
			b_rows = 4'd8;
			b_cols = 4'd8;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [3:0] v);
			case (idx)
				REG_A_ROWS: a_rows = v;
				REG_A_COLS: a_cols = v;
				REG_B_ROWS: b_rows = v;
				REG_B_COLS: b_cols = v;
				default: ;
			endcase
		endfunction

		function void push(status_t st, logic [2:0] r, logic [2:0] c, logic [35:0] s,
				logic l);
			mme_word_t w;
			w.status = st;
			w.row    = r;
			w.col    = c;
			w.total  = s;
			w.last   = l;
			awaited.push_back(w);
		endfunction

		function void predict_item(logic [1:0] op, logic [2:0] row, logic [2:0] col,
				logic [15:0] value);
			int unsigned       nr, nc, m, n, p;
			logic signed [35:0] acc;
			logic signed [15:0] x, y;
			case (op)
				OP_WRITE_A, OP_WRITE_B: begin
					nr = act_dim(op == OP_WRITE_A ? a_rows : b_rows);
					nc = act_dim(op == OP_WRITE_A ? a_cols : b_cols);
					if (row >= nr || col >= nc) begin
						push(STAT_RANGE, '0, '0, '0, 1'b1);
					end else begin
						if (op == OP_WRITE_A) a_mem[row*DIM + col] = value;
						else b_mem[row*DIM + col] = value;
						push(STAT_DONE, '0, '0, '0, 1'b1);
					end
				end
				OP_MULT: begin
					m = act_dim(a_rows);
					n = act_dim(a_cols);
					p = act_dim(b_cols);
					if (n != act_dim(b_rows)) begin
						push(STAT_MISMATCH, '0, '0, '0, 1'b1);
					end else begin
						for (int i = 0; i < m; i++) begin
							for (int j = 0; j < p; j++) begin
								acc = '0;
								for (int k = 0; k < n; k++) begin
									x = a_mem[i*DIM + k];
									y = b_mem[k*DIM + j];
									acc = acc + x * y;
								end
								push(STAT_PRODUCT, 3'(i), 3'(j), acc,
									i == m - 1 && j == p - 1);
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) $display("%t: %s", $realtime, msg);
		endfunction

		function void check_word(logic [1:0] st, logic [2:0] r, logic [2:0] c,
				logic [35:0] s, logic l);
			mme_word_t w;
			if (awaited.size() == 0) begin
				flag($sformatf("unexpected word: status %0d row %0d col %0d sum %0d last %0d",
					st, r, c, $signed(s), l));
				return;
			end
			w = awaited.pop_front();
			if (w.status != st || w.row != r || w.col != c || w.total != s || w.last != l)
				flag($sformatf({"word mismatch: expected status %0d row %0d col %0d sum %0d ",
					"last %0d, got status %0d row %0d col %0d sum %0d last %0d"},
					w.status, w.row, w.col, $signed(w.total), w.last,
					st, r, c, $signed(s), l));
		endfunction
	endclass

	matmul_scoreboard sb = new();

	matrix_multiply_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Small sizes dominate so that products stay short; 0 and values above 8 appear too.
	function automatic logic [3:0] pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 4'($urandom_range(1, 4));
		if (r < 85) return 4'($urandom_range(5, 8));
		if (r < 92) return 4'd0;
		return 4'($urandom_range(9, 15));
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(logic [1:0] op, logic [2:0] row, logic [2:0] col,
			logic [15:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, value, col, row};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		sb.predict_item(op, row, col, value);
		@(negedge clk);
	endtask

	// Holds the sender off until every awaited word is in, then lets the block settle.
	task automatic drain();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [3:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic write_config(logic [3:0] ar, logic [3:0] ac, logic [3:0] br,
			logic [3:0] bc);
		write_reg(REG_A_ROWS, ar);
		write_reg(REG_A_COLS, ac);
		write_reg(REG_B_ROWS, br);
		write_reg(REG_B_COLS, bc);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: random stalls, none while calm.
	initial begin
		int stall;
		stall = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tuser, m_tdata[2:0], m_tdata[5:3], m_tdata[41:6], m_tlast);
	end

	initial begin
		int          sent, nwr, nmul;
		logic [1:0]  op;
		logic [2:0]  r, c;
		logic [3:0]  ar, ac, br, bc;
		int unsigned nr, nc;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		calm      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Products of the cleared stores, then the element extremes at the corners.
		send_word(OP_MULT, 3'd7, 3'd7, 16'hFFFF);
		send_word(OP_WRITE_A, 3'd0, 3'd0, 16'h7FFF);
		send_word(OP_WRITE_A, 3'd7, 3'd7, 16'h8000);
		send_word(OP_WRITE_A, 3'd0, 3'd7, 16'hFFFF);
		send_word(OP_WRITE_B, 3'd0, 3'd0, 16'h8000);
		send_word(OP_WRITE_B, 3'd7, 3'd7, 16'h7FFF);
		send_word(OP_WRITE_B, 3'd7, 3'd0, 16'h8000);
		send_word(OP_UNUSED, 3'd5, 3'd2, 16'h1234);
		send_word(OP_MULT, 3'd0, 3'd0, 16'h0000);
		drain();

		// Out-of-range rows and columns on both stores; old elements keep their place.
		write_config(4'd2, 4'd3, 4'd3, 4'd2);
		send_word(OP_WRITE_A, 3'd2, 3'd0, 16'h0100);
		send_word(OP_WRITE_A, 3'd1, 3'd3, 16'h0200);
		send_word(OP_WRITE_B, 3'd3, 3'd1, 16'h0300);
		send_word(OP_WRITE_B, 3'd2, 3'd2, 16'h0400);
		send_word(OP_WRITE_A, 3'd1, 3'd2, 16'h8000);
		send_word(OP_WRITE_B, 3'd2, 3'd1, 16'h8000);
		send_word(OP_MULT, 3'd3, 3'd4, 16'hA5A5);
		drain();

		write_config(4'd2, 4'd3, 4'd2, 4'd2);
		send_word(OP_MULT, 3'd0, 3'd0, 16'h0000);
		drain();

		// Sizes of 0 and above 8 act as 1 and 8.
		write_config(4'd0, 4'd15, 4'd12, 4'd0);
		send_word(OP_WRITE_A, 3'd1, 3'd0, 16'h0001);
		send_word(OP_WRITE_A, 3'd0, 3'd7, 16'h7FFF);
		send_word(OP_MULT, 3'd0, 3'd0, 16'h0000);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			calm = ($urandom_range(0, 3) == 0);
			ar = pick_dim();
			ac = pick_dim();
			br = ($urandom_range(0, 4) != 0) ? ac : pick_dim();
			bc = pick_dim();
			write_config(ar, ac, br, bc);
			nwr = $urandom_range(3, 14);
			for (int i = 0; i < nwr; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_word(OP_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
				op = $urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A;
				nr = act_dim(op == OP_WRITE_A ? ar : br);
				nc = act_dim(op == OP_WRITE_A ? ac : bc);
				if ($urandom_range(0, 9) != 0) begin
					r = 3'($urandom_range(0, nr - 1));
					c = 3'($urandom_range(0, nc - 1));
				end else begin
					r = 3'($urandom);
					c = 3'($urandom);
				end
				send_word(op, r, c, pick_value());
				sent++;
				if ($urandom_range(0, 29) == 0) drain();
			end
			nmul = ($urandom_range(0, 3) == 0) ? 2 : 1;
			repeat (nmul) begin
				send_word(OP_MULT, 3'($urandom), 3'($urandom), 16'($urandom));
				sent++;
			end
		end

		drain();
		if (sb.awaited.size() != 0)
			sb.flag($sformatf("%0d awaited words never arrived", sb.awaited.size()));
		if (sb.errors == 0) begin
			$display("tb_matrix_multiply_engine passed");
		end else begin
			$display("tb_matrix_multiply_engine failed");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tb_matrix_multiply_engine failed");
		$finish;
	end

endmodule
